[rtl/accel_lowpass_tilt_assert.svh]
// Assertion macros used by the accel_lowpass_tilt top level.
`ifndef ACCEL_LOWPASS_TILT_ASSERT_SVH
`define ACCEL_LOWPASS_TILT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ALT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ALT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ALT_ASSERT_IMP(lbl, ante, cons)
`define ALT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/alt_pkg.sv]
// Types, constants and the arctangent table of the accelerometer filter and tilt block.
package alt_pkg;

	localparam int WORD_W  = 16;
	localparam int SAMP_W  = 14;
	localparam int ALPHA_W = 16;
	localparam int IN_W    = 48;
	localparam int OUT_W   = 48;
	localparam int CNT_W   = 2;
	localparam int MUL_W   = 17;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SQ_W    = 27;
	localparam int SUM_W   = 28;
	localparam int RAD_W   = 44;
	localparam int ROOT_W  = 22;
	localparam int XY_W    = 25;
	localparam int Z_W     = 24;
	localparam int ATAN_W  = 22;
	localparam int ATAN_LEN = 24;
	localparam int IDX_W   = 5;

	typedef enum logic [1:0] {
		MODE_RAW      = 2'd0,
		MODE_FILT     = 2'd1,
		MODE_TILT     = 2'd2,
		MODE_TILT_ALT = 2'd3
	} mode_t;

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_ALPHA = 1'b1;

	localparam mode_t              MODE_RST  = MODE_TILT;
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd3873;

	localparam logic [CNT_W-1:0] CNT_AXES = 2'd3;
	localparam logic [CNT_W-1:0] CNT_TILT = 2'd2;

	localparam logic [1:0] AX_X    = 2'd0;
	localparam logic [1:0] AX_Y    = 2'd1;
	localparam logic [1:0] AX_LAST = 2'd2;

	localparam logic signed [SAMP_W-1:0] TILT_MAX = 14'sd90;
	localparam logic signed [SAMP_W-1:0] TILT_MIN = -14'sd90;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FMUL,
		ST_FADD,
		ST_SMUL,
		ST_SSTO,
		ST_TSTART,
		ST_SQRT,
		ST_CORD,
		ST_DONE
	} st_t;

	// atan(2^-i) in degrees, Q16
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [IDX_W-1:0] i);
		logic [ATAN_W-1:0] v;
		case (i)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/alt_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
module alt_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [alt_pkg::RAD_W-1:0]  radicand,
	output logic                       done,
	output logic [alt_pkg::ROOT_W-1:0] root
);
	import alt_pkg::*;

	localparam int STEP_W = $clog2(ROOT_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              fits;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[rtl/alt_cordic.sv]
// Vectoring CORDIC, one micro-rotation per cycle, angle accumulated in degrees Q16.
module alt_cordic #(
	parameter int STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [alt_pkg::ROOT_W-1:0]      x0,
	input  logic [alt_pkg::ROOT_W-1:0]      y0,
	output logic                            done,
	output logic signed [alt_pkg::Z_W-1:0]  angle
);
	import alt_pkg::*;

	localparam int LAST  = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;
	localparam int ITR_W = $clog2(LAST);

	logic                    busy_q;
	logic                    done_q;
	logic [ITR_W-1:0]        i_q;
	logic signed [XY_W-1:0]  x_q;
	logic signed [XY_W-1:0]  y_q;
	logic signed [Z_W-1:0]   z_q;
	logic signed [XY_W-1:0]  dx;
	logic signed [XY_W-1:0]  dy;
	logic signed [Z_W-1:0]   da;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign da = {{(Z_W - ATAN_W){1'b0}}, atan_q16(IDX_W'(i_q))};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == ITR_W'(LAST - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= XY_W'(x0);
			y_q <= XY_W'(y0);
			z_q <= '0;
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end else if (y_q < 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end
		end
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

[rtl/accel_lowpass_tilt.sv]
// Top level: accelerometer low-pass filter and tilt angle unit.
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    x_word, y_word, z_word
// m_axis    out  m_axis_tvalid/m_axis_tready    value_count, first/second/third_value
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// One item at a time; s_axis_tready is high only while idle.
// Raw mode goes from idle straight to done. Filter mode uses one shared 17x17 multiplier,
// with a multiply and an add state per axis. Tilt mode runs the bit-serial square root
// and then the CORDIC for each angle, both skipped for an angle whose divisor is zero.
// A finished result waits in the output register; an m_axis stall holds the sequencer in done.
// Reset clears the filter state and restores mode 2, alpha 3873; cfg_ready is always high.
`include "accel_lowpass_tilt_assert.svh"
module accel_lowpass_tilt #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [alt_pkg::IN_W-1:0]    s_axis_tdata,  // x_word, y_word, z_word
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [alt_pkg::OUT_W-1:0]   m_axis_tdata,  // value_count, first, second, third, pad
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [alt_pkg::ALPHA_W-1:0] cfg_data
);
	import alt_pkg::*;

	st_t                      state_q, state_d;
	mode_t                    mode_q;
	logic [ALPHA_W-1:0]       alpha_q;
	logic signed [SAMP_W-1:0] samp_q [3];
	logic signed [SAMP_W-1:0] filt_q [3];
	logic [SQ_W-1:0]          sq_q [3];
	logic signed [SAMP_W-1:0] tilt_q [2];
	logic signed [PROD_W-1:0] prod_q;
	logic [1:0]               ax_q;
	logic                     tsel_q;

	logic                     out_valid_q;
	logic [CNT_W-1:0]         out_cnt_q;
	logic signed [SAMP_W-1:0] out_v1_q, out_v2_q, out_v3_q;

	logic in_acc, sqrt_start, cord_start, out_load;
	logic sqrt_done, cord_done;
	logic [ROOT_W-1:0] root;
	logic signed [Z_W-1:0] angle;

	logic signed [SAMP_W-1:0] s_cur, f_cur, n_cur;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic [PROD_W-1:0]        num, num_adj;
	logic signed [SAMP_W-1:0] f_new;
	logic [1:0]               n_idx, p_idx;
	logic [SUM_W-1:0]         sumsq;
	logic [SAMP_W-1:0]        n_abs;
	logic [Z_W-1:0]           z_adj;
	logic signed [Z_W-17:0]   deg;
	logic signed [SAMP_W-1:0] deg_w, deg_cap, tilt_val, tilt_zero;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RST;
			alpha_q <= ALPHA_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= mode_t'(cfg_data[1:0]);
				REG_ALPHA: alpha_q <= cfg_data;
			endcase
		end
	end

	// datapath
	assign s_cur = samp_q[ax_q];
	assign f_cur = filt_q[ax_q];

	always_comb begin
		if (state_q == ST_FMUL) begin
			mul_a = MUL_W'($signed({1'b0, alpha_q}));
			mul_b = MUL_W'(s_cur) - MUL_W'(f_cur);
		end else begin
			mul_a = MUL_W'(f_cur);
			mul_b = MUL_W'(f_cur);
		end
	end
	assign prod_d = mul_a * mul_b;

	// f + a*(s-f)/2^16, truncated toward zero
	assign num     = {{(PROD_W - SAMP_W - ALPHA_W){f_cur[SAMP_W-1]}}, f_cur, {ALPHA_W{1'b0}}}
		+ prod_q;
	assign num_adj = num + (num[PROD_W-1] ? PROD_W'({ALPHA_W{1'b1}}) : '0);
	assign f_new   = num_adj[SAMP_W+ALPHA_W-1:ALPHA_W];

	assign n_idx = tsel_q ? AX_Y : AX_X;
	assign p_idx = tsel_q ? AX_X : AX_Y;
	assign n_cur = filt_q[n_idx];
	assign sumsq = SUM_W'(sq_q[p_idx]) + SUM_W'(sq_q[AX_LAST]);
	assign n_abs = n_cur[SAMP_W-1] ? SAMP_W'(~n_cur + 1'b1) : n_cur;

	assign z_adj = angle + (angle[Z_W-1] ? Z_W'({ALPHA_W{1'b1}}) : '0);
	assign deg   = z_adj[Z_W-1:16];
	assign deg_w = SAMP_W'(deg);

	always_comb begin
		priority if (deg_w > TILT_MAX) deg_cap = TILT_MAX;
		else if (deg_w < TILT_MIN) deg_cap = TILT_MIN;
		else deg_cap = deg_w;
	end
	assign tilt_val = n_cur[SAMP_W-1] ? -deg_cap : deg_cap;

	always_comb begin
		priority if (n_cur > 0) tilt_zero = TILT_MAX;
		else if (n_cur < 0) tilt_zero = TILT_MIN;
		else tilt_zero = '0;
	end

	alt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({sumsq, {ALPHA_W{1'b0}}}),
		.done     (sqrt_done),
		.root     (root)
	);

	alt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.x0     (root),
		.y0     ({n_abs, 8'd0}),
		.done   (cord_done),
		.angle  (angle)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		sqrt_start    = 1'b0;
		cord_start    = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = (mode_q == MODE_RAW) ? ST_DONE : ST_FMUL;
			end
			ST_FMUL: state_d = ST_FADD;
			ST_FADD: begin
				if (ax_q != AX_LAST) state_d = ST_FMUL;
				else if (mode_q == MODE_FILT) state_d = ST_DONE;
				else state_d = ST_SMUL;
			end
			ST_SMUL: state_d = ST_SSTO;
			ST_SSTO: state_d = (ax_q == AX_LAST) ? ST_TSTART : ST_SMUL;
			ST_TSTART: begin
				if (sumsq != '0) begin
					sqrt_start = 1'b1;
					state_d    = ST_SQRT;
				end else if (tsel_q) begin
					state_d = ST_DONE;
				end
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					cord_start = 1'b1;
					state_d    = ST_CORD;
				end
			end
			ST_CORD: begin
				if (cord_done) state_d = tsel_q ? ST_DONE : ST_TSTART;
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q   <= AX_X;
			tsel_q <= 1'b0;
			for (int k = 0; k < 3; k++) filt_q[k] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ax_q   <= AX_X;
					tsel_q <= 1'b0;
				end
				ST_FADD: begin
					filt_q[ax_q] <= f_new;
					ax_q <= (ax_q == AX_LAST) ? AX_X : ax_q + 1'b1;
				end
				ST_SSTO: ax_q <= (ax_q == AX_LAST) ? AX_X : ax_q + 1'b1;
				ST_TSTART: if (sumsq == '0) tsel_q <= 1'b1;
				ST_CORD: if (cord_done) tsel_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_q[0] <= $signed(s_axis_tdata[WORD_W-1:2]);
			samp_q[1] <= $signed(s_axis_tdata[2*WORD_W-1:WORD_W+2]);
			samp_q[2] <= $signed(s_axis_tdata[3*WORD_W-1:2*WORD_W+2]);
		end
		if (state_q == ST_FMUL || state_q == ST_SMUL) prod_q <= prod_d;
		if (state_q == ST_SSTO) sq_q[ax_q] <= prod_q[SQ_W-1:0];
		if (state_q == ST_TSTART && sumsq == '0) tilt_q[tsel_q] <= tilt_zero;
		if (state_q == ST_CORD && cord_done) tilt_q[tsel_q] <= tilt_val;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			unique case (mode_q)
				MODE_RAW: begin
					out_cnt_q <= CNT_AXES;
					out_v1_q  <= samp_q[0];
					out_v2_q  <= samp_q[1];
					out_v3_q  <= samp_q[2];
				end
				MODE_FILT: begin
					out_cnt_q <= CNT_AXES;
					out_v1_q  <= filt_q[0];
					out_v2_q  <= filt_q[1];
					out_v3_q  <= filt_q[2];
				end
				MODE_TILT, MODE_TILT_ALT: begin
					out_cnt_q <= CNT_TILT;
					out_v1_q  <= tilt_q[0];
					out_v2_q  <= tilt_q[1];
					out_v3_q  <= '0;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W - CNT_W - 3*SAMP_W){1'b0}}, out_v3_q, out_v2_q, out_v1_q,
		out_cnt_q};

	`ALT_ASSERT_NEXT(a_one_item_in_flight, in_acc, !s_axis_tready)
	`ALT_ASSERT_IMP(a_tilt_third_zero, out_valid_q && out_cnt_q == CNT_TILT, out_v3_q == '0)
	`ALT_ASSERT_IMP(a_tilt_first_range, out_valid_q && out_cnt_q == CNT_TILT, out_v1_q <= TILT_MAX && out_v1_q >= TILT_MIN)
	`ALT_ASSERT_IMP(a_tilt_second_range, out_valid_q && out_cnt_q == CNT_TILT, out_v2_q <= TILT_MAX && out_v2_q >= TILT_MIN)

endmodule
